FILE: rtl/assert_macros.svh
// assertion macros for the rtl, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define ERFCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ERFCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/erfcs_pkg.sv
// shared types and constants of the erf coulomb direct-sum evaluator
package erfcs_pkg;

  // input item kinds carried on s_tuser
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_TARGET = 1'b1;

  // configuration register indexes
  localparam logic CFG_ETA          = 1'b0;
  localparam logic CFG_SOURCE_COUNT = 1'b1;

  // 1.0 in q1.30, the value erf saturates to
  localparam logic [30:0] ERF_ONE = 31'h4000_0000;

  // divider geometry: dividend bits and divisor bits
  localparam int DIV_NW = 80;
  localparam int DIV_DW = 34;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_READ,
    S_SQX,
    S_SQY,
    S_SQZ,
    S_ROOT,
    S_RCHK,
    S_UDIV,
    S_ERF_IDX,
    S_ERF_LO,
    S_ERF_HI0,
    S_ERF_HI1,
    S_ERF_SUM,
    S_MAG,
    S_AHI,
    S_ALO,
    S_ASUM,
    S_TDIV,
    S_TERM,
    S_FINISH
  } state_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

FILE: rtl/erfcs_ram.sv
// generic single-write, single-read synchronous ram with registered read
module erfcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/erfcs_erf_rom.sv
// erf table in q1.30, built at elaboration, registered read
module erfcs_erf_rom #(
  parameter int ERF_TABLE_SIZE = 1024,
  localparam int IW = $clog2(ERF_TABLE_SIZE + 1)
) (
  input  logic          clk,
  input  logic [IW-1:0] addr,
  output logic [30:0]   q
);

  localparam logic [63:0] N2      = 64'(ERF_TABLE_SIZE) * 64'(ERF_TABLE_SIZE);
  localparam logic [63:0] THREE_N = 64'(3) * 64'(ERF_TABLE_SIZE);
  localparam logic [63:0] Q31     = 64'h8000_0000;
  localparam logic [63:0] Q30     = 64'h4000_0000;
  localparam logic [63:0] SCALE   = 64'd1211587905;

  typedef logic [30:0] rom_t [ERF_TABLE_SIZE + 1];

  // exp(-t^2) in q1.31 at t = 2i/size
  function automatic logic [63:0] gauss(input logic [63:0] i);
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] sum;
    z = ((i * i) << 25) / N2;
    term = Q31;
    sum = Q31;
    term = ((term * z) >> 31);      sum = sum - term;
    term = ((term * z) >> 31) / 2;  sum = sum + term;
    term = ((term * z) >> 31) / 3;  sum = sum - term;
    term = ((term * z) >> 31) / 4;  sum = sum + term;
    term = ((term * z) >> 31) / 5;  sum = sum - term;
    term = ((term * z) >> 31) / 6;  sum = sum + term;
    term = ((term * z) >> 31) / 7;  sum = sum - term;
    term = ((term * z) >> 31) / 8;  sum = sum + term;
    term = ((term * z) >> 31) / 9;  sum = sum - term;
    term = ((term * z) >> 31) / 10; sum = sum + term;
    for (int s = 0; s < 8; s++) begin
      sum = (sum * sum) >> 31;
    end
    return sum;
  endfunction

  // simpson integral of the gaussian, scaled by 2/sqrt(pi), clamped to 1.0
  function automatic rom_t build_rom();
    rom_t t;
    logic [63:0] acc;
    logic [63:0] i31;
    logic [63:0] e;
    logic [63:0] k2;
    acc = '0;
    t[0] = '0;
    for (int k = 0; k < ERF_TABLE_SIZE; k++) begin
      k2 = 64'(2 * k);
      acc = acc + gauss(k2) + 64'(4) * gauss(k2 + 64'd1) + gauss(k2 + 64'd2);
      i31 = (acc * 64'd2) / THREE_N;
      e = (i31 * SCALE) >> 31;
      if (e > Q30) begin
        e = Q30;
      end
      t[k + 1] = e[30:0];
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  // registered lookup
  always_ff @(posedge clk) begin
    q <= ROM[addr];
  end

endmodule

FILE: rtl/erfcs_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module erfcs_div
  import erfcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output div_status_t       status,
  output logic [DIV_NW-1:0] quo
);

  localparam int CNTW = $clog2(DIV_NW);

  logic [DIV_DW:0]   rem;
  logic [DIV_DW-1:0] dreg;
  logic [CNTW-1:0]   step;
  logic [DIV_DW:0]   rem_sh;
  logic              fits;

  // shift in the next dividend bit and try the divisor
  always_comb begin
    rem_sh = {rem[DIV_DW-1:0], quo[DIV_NW-1]};
    fits = (rem_sh >= {1'b0, dreg});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      step <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        status.busy <= 1'b1;
        step <= '0;
      end else if (status.busy) begin
        step <= step + 1'b1;
        if (step == CNTW'(DIV_NW - 1)) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dreg <= den;
    end else if (status.busy) begin
      rem <= fits ? (rem_sh - {1'b0, dreg}) : rem_sh;
      quo <= {quo[DIV_NW-2:0], fits};
    end
  end

endmodule

FILE: rtl/erf_coulomb_direct_sum.sv
// top level: direct sum of the erf-smoothed coulomb kernel over stored sources
//
//  channel  dir  handshake                what moves
//  s_*      in   s_tvalid / s_tready      load or target beat
//  m_*      out  m_tvalid / m_tready      potential beat, one per target
//  cfg_*    in   cfg_valid / cfg_ready    register write
//
// a load is written to the store without leaving S_IDLE. a target walks its N
// summed sources in turn: each goes through a 34-step square root and two
// 80-step bit-serial divisions (only the a/r one when eta is 0); a coincident
// source skips the divisions. rst is synchronous and clears control state only;
// the source store has no clearing pass. a finished target waits in S_FINISH
// while the output register still holds an unsent beat, and s_tready stays low
// until that beat moves.
`include "assert_macros.svh"

module erf_coulomb_direct_sum
  import erfcs_pkg::*;
#(
  parameter int MAX_SOURCES    = 256,
  parameter int ERF_TABLE_SIZE = 1024
) (
  input  logic         clk,
  input  logic         rst,
  // slot[7:0], pos_x[39:8], pos_y[71:40], pos_z[103:72], charge[135:104],
  // weight[167:136], prior_potential[231:168]
  input  logic [231:0] s_tdata,
  // mode[0]
  input  logic         s_tuser,
  input  logic         s_tvalid,
  output logic         s_tready,
  // potential[63:0]
  output logic [63:0]  m_tdata,
  // saturated[0]
  output logic         m_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int CW = $clog2(MAX_SOURCES + 1);
  localparam int IW = $clog2(ERF_TABLE_SIZE + 1);

  // configuration registers
  logic [31:0] eta;
  logic [8:0]  source_count;

  // sequencer
  state_t state, state_next;

  // target context
  logic [31:0] tx, ty, tz;
  logic [63:0] prior;
  logic [63:0] acc;
  logic        clip;
  logic [CW-1:0] j, cnt, cnt_cfg;

  // per-source datapath registers
  logic [67:0] rad;
  logic [36:0] rem;
  logic [33:0] root;
  logic [6:0]  rstep;
  logic [IW-1:0] eidx;
  logic [15:0] efrac;
  logic [47:0] p0, p1;
  logic [30:0] e;
  logic [63:0] m;
  logic [62:0] ah, al;

  // memory and units
  logic [159:0] ram_rdata;
  logic         ram_we;
  logic [30:0]  rom_q;
  logic [IW-1:0] rom_addr;
  div_status_t  div_stat;
  logic         div_start;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;

  // combinational helpers
  logic        in_acc;
  logic [31:0] s_pos, t_pos;
  logic [32:0] diff, dabs;
  logic [65:0] sq;
  logic [36:0] rem_sh, trial;
  logic [31:0] pidx;
  logic [31:0] qa, wa;
  logic [63:0] a_sum;
  logic        neg, big;
  logic [63:0] mag, tv;
  logic [64:0] acc_add, fin_add;
  logic        adv_last;

  // saturating signed add, clip flag on top
  function automatic logic [64:0] sat_add(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] s;
    logic        c;
    s = x + y;
    c = 1'b0;
    if ((x[63] == y[63]) && (s[63] != x[63])) begin
      c = 1'b1;
      s = x[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return {c, s};
  endfunction

  assign cfg_ready = 1'b1;
  assign s_tready = (state == S_IDLE);
  assign in_acc = s_tvalid && s_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      eta <= 32'd65536;
      source_count <= 9'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ETA:          eta <= cfg_data;
        CFG_SOURCE_COUNT: source_count <= cfg_data[8:0];
        default:          ;
      endcase
    end
  end

  // clamp the configured count to the store depth
  always_comb begin
    if (32'(source_count) > 32'(MAX_SOURCES)) begin
      cnt_cfg = CW'(MAX_SOURCES);
    end else begin
      cnt_cfg = CW'(source_count);
    end
  end

  // source store: x, y, z, charge, weight from the lowest bits up
  assign ram_we = in_acc && (s_tuser == MODE_LOAD) && (32'(s_tdata[7:0]) < 32'(MAX_SOURCES));

  erfcs_ram #(
    .WIDTH(160),
    .DEPTH(MAX_SOURCES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(s_tdata[7:0])),
    .wdata(s_tdata[167:8]),
    .re   (state == S_READ),
    .raddr(j[AW-1:0]),
    .rdata(ram_rdata)
  );

  // erf table, second read picks the upper neighbor
  assign rom_addr = (state == S_ERF_HI0) ? IW'(eidx + 1'b1) : eidx;

  erfcs_erf_rom #(
    .ERF_TABLE_SIZE(ERF_TABLE_SIZE)
  ) u_erf (
    .clk (clk),
    .addr(rom_addr),
    .q   (rom_q)
  );

  // shared divider: r/eta for the erf argument, then a/r for the term
  assign div_start = ((state == S_RCHK) && (root != '0) && (eta != '0)) ||
                     (state == S_ASUM);
  assign div_num = (state == S_ASUM) ? {a_sum, 16'd0} : {30'd0, root, 16'd0};
  assign div_den = (state == S_ASUM) ? root : {2'b00, eta};

  erfcs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .status(div_stat),
    .quo   (div_quo)
  );

  // squared distance, root step, product and term arithmetic
  always_comb begin
    case (state)
      S_SQY:   begin s_pos = ram_rdata[63:32]; t_pos = ty; end
      S_SQZ:   begin s_pos = ram_rdata[95:64]; t_pos = tz; end
      default: begin s_pos = ram_rdata[31:0];  t_pos = tx; end
    endcase
    diff = {t_pos[31], t_pos} - {s_pos[31], s_pos};
    dabs = diff[32] ? (33'd0 - diff) : diff;
    sq = dabs * dabs;
    rem_sh = {rem[34:0], rad[67:66]};
    trial = {1'b0, root, 2'b01};
    pidx = 32'(div_quo[17:0]) * 32'(ERF_TABLE_SIZE);
    qa = ram_rdata[127] ? (32'd0 - ram_rdata[127:96]) : ram_rdata[127:96];
    wa = ram_rdata[159] ? (32'd0 - ram_rdata[159:128]) : ram_rdata[159:128];
    a_sum = {ah[61:0], 2'b00} + {31'd0, al[62:30]};
    neg = ram_rdata[127] ^ ram_rdata[159];
    big = (div_quo[79:63] != '0);
    if (big) begin
      mag = neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      mag = {1'b0, div_quo[62:0]};
    end
    tv = neg ? (64'd0 - mag) : mag;
    acc_add = sat_add(acc, tv);
    fin_add = sat_add(prior, acc);
    adv_last = (CW'(j + 1'b1) == cnt);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && (s_tuser == MODE_TARGET)) begin
          state_next = (cnt_cfg == '0) ? S_FINISH : S_READ;
        end
      end
      S_READ:    state_next = S_SQX;
      S_SQX:     state_next = S_SQY;
      S_SQY:     state_next = S_SQZ;
      S_SQZ:     state_next = S_ROOT;
      S_ROOT: begin
        if (rstep == 7'd33) begin
          state_next = S_RCHK;
        end
      end
      S_RCHK: begin
        if (root == '0) begin
          state_next = adv_last ? S_FINISH : S_READ;
        end else if (eta == '0) begin
          state_next = S_MAG;
        end else begin
          state_next = S_UDIV;
        end
      end
      S_UDIV: begin
        if (div_stat.done) begin
          state_next = S_ERF_IDX;
        end
      end
      S_ERF_IDX: state_next = (div_quo[79:18] != '0) ? S_MAG : S_ERF_LO;
      S_ERF_LO:  state_next = S_ERF_HI0;
      S_ERF_HI0: state_next = S_ERF_HI1;
      S_ERF_HI1: state_next = S_ERF_SUM;
      S_ERF_SUM: state_next = S_MAG;
      S_MAG:     state_next = S_AHI;
      S_AHI:     state_next = S_ALO;
      S_ALO:     state_next = S_ASUM;
      S_ASUM:    state_next = S_TDIV;
      S_TDIV: begin
        if (div_stat.done) begin
          state_next = S_TERM;
        end
      end
      S_TERM:    state_next = adv_last ? S_FINISH : S_READ;
      S_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc && (s_tuser == MODE_TARGET)) begin
          tx <= s_tdata[39:8];
          ty <= s_tdata[71:40];
          tz <= s_tdata[103:72];
          prior <= s_tdata[231:168];
          acc <= '0;
          clip <= 1'b0;
          j <= '0;
          cnt <= cnt_cfg;
        end
      end
      S_SQX: rad <= 68'(sq);
      S_SQY: rad <= rad + 68'(sq);
      S_SQZ: begin
        rad <= rad + 68'(sq);
        rem <= '0;
        root <= '0;
        rstep <= '0;
      end
      S_ROOT: begin
        if (rem_sh >= trial) begin
          rem <= rem_sh - trial;
          root <= {root[32:0], 1'b1};
        end else begin
          rem <= rem_sh;
          root <= {root[32:0], 1'b0};
        end
        rad <= {rad[65:0], 2'b00};
        rstep <= rstep + 1'b1;
      end
      S_RCHK: begin
        if (root == '0) begin
          j <= CW'(j + 1'b1);
        end else if (eta == '0) begin
          e <= ERF_ONE;
        end
      end
      S_ERF_IDX: begin
        if (div_quo[79:18] != '0) begin
          e <= ERF_ONE;
        end
        eidx <= IW'(pidx >> 18);
        efrac <= pidx[17:2];
      end
      S_ERF_HI0: p0 <= 48'(rom_q * (17'd65536 - {1'b0, efrac}));
      S_ERF_HI1: p1 <= 48'(rom_q * {1'b0, efrac});
      S_ERF_SUM: e <= 31'((49'(p0) + 49'(p1)) >> 16);
      S_MAG:     m <= qa * wa;
      S_AHI:     ah <= 63'(m[63:32] * e);
      S_ALO:     al <= 63'(m[31:0] * e);
      S_TERM: begin
        acc <= acc_add[63:0];
        clip <= clip | big | acc_add[64];
        j <= CW'(j + 1'b1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_FINISH) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata <= fin_add[63:0];
      m_tuser <= clip | fin_add[64];
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // checks
  `ERFCS_ASSERT_NEXT(a_target_busy, in_acc && (s_tuser == MODE_TARGET), !s_tready,
    "target accepted but input still ready")
  `ERFCS_ASSERT_SAME(a_div_done_owner, div_stat.done,
    (state == S_UDIV) || (state == S_TDIV), "divider finished with no waiting state")
  `ERFCS_ASSERT_SAME(a_slot_in_range, (state != S_IDLE) && (state != S_FINISH), j < cnt,
    "source walk past the summed count")
  `ERFCS_ASSERT_NEXT(a_load_silent, in_acc && (s_tuser == MODE_LOAD) && !m_tvalid, !m_tvalid,
    "load produced a result beat")

endmodule
